// ----- design/acpi_s5_pkg.sv -----
// Package for the ACPI DSDT S5 sleep-type parser.
// Holds the parse phase and status codes, AML constants and shared structs.
// Depends on nothing.
`timescale 1ns / 1ps

package acpi_s5_pkg;

	localparam logic [31:0] SIG_RESET  = 32'h5444_5344;
	localparam logic [31:0] NAME_RESET = 32'h5F35_535F;

	localparam logic [31:0] HEADER_BYTES = 32'd36;
	localparam logic [7:0]  PACKAGE_OP   = 8'h12;
	localparam logic [7:0]  BYTE_PREFIX  = 8'h0A;
	localparam logic [7:0]  NAME_OP      = 8'h08;
	localparam logic [7:0]  ROOT_CHAR    = 8'h5C;

	localparam logic [0:0] REG_TABLE_SIGNATURE = 1'd0;
	localparam logic [0:0] REG_OBJECT_NAME     = 1'd1;

	localparam logic [3:0] PH_SEARCH    = 4'd0;
	localparam logic [3:0] PH_FOUND     = 4'd1;
	localparam logic [3:0] PH_LEAD      = 4'd2;
	localparam logic [3:0] PH_SKIPPKG   = 4'd3;
	localparam logic [3:0] PH_COUNT     = 4'd4;
	localparam logic [3:0] PH_A_FIRST   = 4'd5;
	localparam logic [3:0] PH_A_VAL     = 4'd6;
	localparam logic [3:0] PH_B_FIRST   = 4'd7;
	localparam logic [3:0] PH_B_VAL     = 4'd8;
	localparam logic [3:0] PH_CAPTURED  = 4'd9;
	localparam logic [3:0] PH_MALFORMED = 4'd10;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIG   = 3'd1;
	localparam logic [2:0] ST_BAD_SUM   = 3'd2;
	localparam logic [2:0] ST_NO_NAME   = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  sleep_type_a;
		logic [7:0]  sleep_type_b;
		logic [31:0] table_length;
	} result_t;

endpackage

// ----- design/acpi_s5_if.sv -----
// Channel interfaces for the ACPI S5 parser: table bytes, results, register writes.
// Each carries valid, ready and its payload. Depends on nothing.
`timescale 1ns / 1ps

interface acpi_s5_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface acpi_s5_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  sleep_type_a;
	logic [7:0]  sleep_type_b;
	logic [31:0] table_length;

	modport source (output valid, status, sleep_type_a, sleep_type_b, table_length,
		input ready);
	modport sink (input valid, status, sleep_type_a, sleep_type_b, table_length,
		output ready);
endinterface

interface acpi_s5_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/acpi_s5_input_reg.sv -----
// Input register stage of the ACPI S5 parser.
// Depends on acpi_s5_pkg and acpi_s5_byte_if.
`timescale 1ns / 1ps

module acpi_s5_input_reg
	import acpi_s5_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	acpi_s5_byte_if.sink       tbl,
	input  logic               advance,
	output logic               valid_s1,
	output byte_item_t         item_s1
);

	assign tbl.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tbl.ready) begin
			valid_s1 <= tbl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl.ready && tbl.valid) begin
			item_s1.data_byte  <= tbl.data_byte;
			item_s1.first_byte <= tbl.first_byte;
			item_s1.last_byte  <= tbl.last_byte;
		end
	end

endmodule

// ----- design/acpi_s5_core.sv -----
// Table state and per-byte parsing logic of the ACPI S5 parser.
// Holds the configuration registers. Depends on acpi_s5_pkg and acpi_s5_cfg_if.
`timescale 1ns / 1ps

module acpi_s5_core
	import acpi_s5_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	acpi_s5_cfg_if.sink   cfg,
	input  logic          valid_s1,
	input  byte_item_t    item_s1,
	input  logic          advance,
	output logic          hit,
	output result_t       result
);

	logic [31:0] sig_q, name_q;
	logic [31:0] pos_q, hlen_q;
	logic [7:0]  sum_q;
	logic        sig_ok_q;
	logic [55:0] hist_q;
	logic [3:0]  phase_q;
	logic [1:0]  skip_q;
	logic [7:0]  type_a_q, type_b_q;
	logic        done_q;

	logic [31:0] c_pos, c_hlen;
	logic [7:0]  c_sum;
	logic        c_sig;
	logic [55:0] c_hist;
	logic [3:0]  c_phase;
	logic [1:0]  c_skip;
	logic [7:0]  c_ta, c_tb;
	logic        c_done;

	logic [7:0]  b;
	logic [31:0] hlen_n;
	logic [7:0]  sum_n, head_sum;
	logic        sig_n;
	logic [3:0]  phase_n;
	logic [1:0]  skip_n;
	logic [7:0]  ta_n, tb_n;
	logic        at_end;
	logic [31:0] cand;
	logic        prefix_ok;
	logic [7:0]  head_bytes [8];
	logic [2:0]  status_n;
	logic        upd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q  <= SIG_RESET;
			name_q <= NAME_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TABLE_SIGNATURE: sig_q  <= cfg.data;
				REG_OBJECT_NAME:     name_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (item_s1.first_byte) begin
			c_pos   = '0;
			c_hlen  = '0;
			c_sum   = '0;
			c_sig   = 1'b1;
			c_hist  = '0;
			c_phase = PH_SEARCH;
			c_skip  = '0;
			c_ta    = '0;
			c_tb    = '0;
			c_done  = 1'b0;
		end else begin
			c_pos   = pos_q;
			c_hlen  = hlen_q;
			c_sum   = sum_q;
			c_sig   = sig_ok_q;
			c_hist  = hist_q;
			c_phase = phase_q;
			c_skip  = skip_q;
			c_ta    = type_a_q;
			c_tb    = type_b_q;
			c_done  = done_q;
		end
	end

	assign b = item_s1.data_byte;

	always_comb begin
		sig_n = c_sig;
		if (c_pos < 32'd4 && b != sig_q[8*c_pos[1:0] +: 8]) begin
			sig_n = 1'b0;
		end
		hlen_n = c_hlen;
		if (c_pos >= 32'd4 && c_pos < 32'd8) begin
			hlen_n[8*c_pos[1:0] +: 8] = c_hlen[8*c_pos[1:0] +: 8] | b;
		end
	end

	// Byte j of the header is in the history, byte 7 is the current byte.
	always_comb begin
		for (int j = 0; j < 7; j++) begin
			head_bytes[j] = c_hist[8*(6-j) +: 8];
		end
		head_bytes[7] = b;
		head_sum = '0;
		for (int j = 0; j < 8; j++) begin
			if (hlen_n > 32'(j)) begin
				head_sum = head_sum + head_bytes[j];
			end
		end
		if (c_pos == 32'd7) begin
			sum_n = head_sum;
		end else if (c_pos > 32'd7) begin
			sum_n = c_sum + b;
		end else begin
			sum_n = c_sum;
		end
	end

	assign cand      = {b, c_hist[7:0], c_hist[15:8], c_hist[23:16]};
	assign prefix_ok = (c_hist[31:24] == NAME_OP)
		|| (c_hist[39:32] == NAME_OP && c_hist[31:24] == ROOT_CHAR);

	always_comb begin
		phase_n = c_phase;
		skip_n  = c_skip;
		ta_n    = c_ta;
		tb_n    = c_tb;
		case (c_phase)
			PH_SEARCH: begin
				if (c_pos >= HEADER_BYTES + 32'd3 && cand == name_q) begin
					phase_n = prefix_ok ? PH_FOUND : PH_MALFORMED;
				end
			end
			PH_FOUND: begin
				phase_n = (b == PACKAGE_OP) ? PH_LEAD : PH_MALFORMED;
			end
			PH_LEAD: begin
				skip_n  = b[7:6];
				phase_n = (b[7:6] != 2'd0) ? PH_SKIPPKG : PH_COUNT;
			end
			PH_SKIPPKG: begin
				skip_n = c_skip - 2'd1;
				if (c_skip == 2'd1) begin
					phase_n = PH_COUNT;
				end
			end
			PH_COUNT: begin
				phase_n = PH_A_FIRST;
			end
			PH_A_FIRST: begin
				if (b == BYTE_PREFIX) begin
					phase_n = PH_A_VAL;
				end else begin
					ta_n    = b;
					phase_n = PH_B_FIRST;
				end
			end
			PH_A_VAL: begin
				ta_n    = b;
				phase_n = PH_B_FIRST;
			end
			PH_B_FIRST: begin
				if (b == BYTE_PREFIX) begin
					phase_n = PH_B_VAL;
				end else begin
					tb_n    = b;
					phase_n = PH_CAPTURED;
				end
			end
			PH_B_VAL: begin
				tb_n    = b;
				phase_n = PH_CAPTURED;
			end
			default: ;
		endcase
	end

	assign at_end = (c_pos == 32'd7 && hlen_n <= 32'd8)
		|| (c_pos > 32'd7 && ({1'b0, c_pos} + 33'd1) == {1'b0, hlen_n});

	always_comb begin
		if (!sig_n) begin
			status_n = ST_BAD_SIG;
		end else if (!at_end) begin
			status_n = ST_TRUNCATED;
		end else if (sum_n != 8'd0) begin
			status_n = ST_BAD_SUM;
		end else if (phase_n == PH_SEARCH) begin
			status_n = ST_NO_NAME;
		end else if (phase_n == PH_CAPTURED) begin
			status_n = ST_OK;
		end else begin
			status_n = ST_MALFORMED;
		end
	end

	assign hit = valid_s1 && !c_done && (at_end || item_s1.last_byte);

	assign result.status       = status_n;
	assign result.sleep_type_a = (status_n == ST_OK) ? ta_n : 8'd0;
	assign result.sleep_type_b = (status_n == ST_OK) ? tb_n : 8'd0;
	assign result.table_length = hlen_n;

	assign upd = valid_s1 && advance && !c_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hlen_q   <= '0;
			sum_q    <= '0;
			sig_ok_q <= 1'b1;
			hist_q   <= '0;
			phase_q  <= PH_SEARCH;
			skip_q   <= '0;
			done_q   <= 1'b1;
		end else if (upd) begin
			pos_q    <= c_pos + 32'd1;
			hlen_q   <= hlen_n;
			sum_q    <= sum_n;
			sig_ok_q <= sig_n;
			hist_q   <= {c_hist[47:0], b};
			phase_q  <= phase_n;
			skip_q   <= skip_n;
			done_q   <= at_end || item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			type_a_q <= ta_n;
			type_b_q <= tb_n;
		end
	end

endmodule

// ----- design/acpi_s5_out_reg.sv -----
// Result register of the ACPI S5 parser, holding one transaction until taken.
// Depends on acpi_s5_pkg and acpi_s5_result_if.
`timescale 1ns / 1ps

module acpi_s5_out_reg
	import acpi_s5_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  result_t           result,
	output logic              space,
	acpi_s5_result_if.source  res
);

	result_t res_q;
	logic    valid_q;

	assign space = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign res.valid        = valid_q;
	assign res.status       = res_q.status;
	assign res.sleep_type_a = res_q.sleep_type_a;
	assign res.sleep_type_b = res_q.sleep_type_b;
	assign res.table_length = res_q.table_length;

endmodule

// ----- design/acpi_dsdt_s5_sleep_type_parser.sv -----
// ACPI DSDT S5 sleep-type parser, top level.
// Path: the byte that ends the table is held in the input register, and its result is then
// loaded into the result register. Throughput: one byte per cycle; a byte held in
// the input register waits only while it would produce a result and the previous one is untaken.
// Reset: idle until a byte with first_byte; registers reset to DSDT and _S5_.
// Depends on acpi_s5_pkg, the channel interfaces and the three stage modules.
`timescale 1ns / 1ps

module acpi_dsdt_s5_sleep_type_parser
	import acpi_s5_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	acpi_s5_byte_if.sink      tbl,
	acpi_s5_result_if.source  res,
	acpi_s5_cfg_if.sink       cfg
);

	logic       valid_s1;
	byte_item_t item_s1;
	logic       advance;
	logic       hit;
	logic       space;
	result_t    result;

	assign advance = valid_s1 && (!hit || space);

	acpi_s5_input_reg u_input_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.tbl      (tbl),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	acpi_s5_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.hit      (hit),
		.result   (result)
	);

	acpi_s5_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (hit && advance),
		.result (result),
		.space  (space),
		.res    (res)
	);

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		hit && advance |=> res.valid)
		else $error("result transaction not presented after load");

	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("held byte lost from input register");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!tbl.ready |-> valid_s1 && hit && res.valid && !res.ready)
		else $error("input stalled without a waiting result");

endmodule

// ----- tb/sv/acpi_s5_tb_pkg.sv -----
// Scoreboard for the ACPI S5 sleep-type parser testbench: tracks the parse of each table
// byte by byte and checks every result against the expected one.
// Depends on acpi_s5_pkg.
`timescale 1ns / 1ps

package acpi_s5_tb_pkg;
	import acpi_s5_pkg::*;

	class sleep_type_scoreboard;
		logic [31:0] signature_reg;
		logic [31:0] name_reg;
		logic [31:0] position;
		logic [31:0] length_field;
		logic [7:0]  checksum;
		logic        signature_ok;
		logic [63:0] window;
		logic [3:0]  phase;
		logic [1:0]  skip_count;
		logic [7:0]  type_a;
		logic [7:0]  type_b;
		logic        idle;
		result_t     expected_results[$];
		int unsigned errors;

		function new();
			signature_reg = SIG_RESET;
			name_reg = NAME_RESET;
			begin_table();
			idle = 1'b1;
			errors = 0;
		endfunction

		function void set_register(logic [0:0] index, logic [31:0] value);
			if (index == REG_TABLE_SIGNATURE) begin
				signature_reg = value;
			end else begin
				name_reg = value;
			end
		endfunction

		function void begin_table();
			position = 32'd0;
			length_field = 32'd0;
			checksum = 8'h00;
			signature_ok = 1'b1;
			window = 64'd0;
			phase = PH_SEARCH;
			skip_count = 2'd0;
			type_a = 8'h00;
			type_b = 8'h00;
			idle = 1'b0;
		endfunction

		function logic [7:0] earlier(int unsigned k);
			return window[k * 8 +: 8];
		endfunction

		function void advance_phase(logic [7:0] b);
			logic [31:0] candidate;
			case (phase)
				PH_SEARCH: begin
					if (position >= HEADER_BYTES + 3) begin
						candidate = {earlier(0), earlier(1), earlier(2), earlier(3)};
						if (candidate == name_reg) begin
							if (earlier(4) == NAME_OP ||
									(earlier(5) == NAME_OP && earlier(4) == ROOT_CHAR))
								phase = PH_FOUND;
							else
								phase = PH_MALFORMED;
						end
					end
				end
				PH_FOUND: phase = (b == PACKAGE_OP) ? PH_LEAD : PH_MALFORMED;
				PH_LEAD: begin
					skip_count = b[7:6];
					phase = (skip_count != 2'd0) ? PH_SKIPPKG : PH_COUNT;
				end
				PH_SKIPPKG: begin
					skip_count = skip_count - 2'd1;
					if (skip_count == 2'd0)
						phase = PH_COUNT;
				end
				PH_COUNT: phase = PH_A_FIRST;
				PH_A_FIRST: begin
					if (b == BYTE_PREFIX) begin
						phase = PH_A_VAL;
					end else begin
						type_a = b;
						phase = PH_B_FIRST;
					end
				end
				PH_A_VAL: begin
					type_a = b;
					phase = PH_B_FIRST;
				end
				PH_B_FIRST: begin
					if (b == BYTE_PREFIX) begin
						phase = PH_B_VAL;
					end else begin
						type_b = b;
						phase = PH_CAPTURED;
					end
				end
				PH_B_VAL: begin
					type_b = b;
					phase = PH_CAPTURED;
				end
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic first, logic last);
			logic [31:0] p;
			logic [31:0] count;
			logic [7:0]  sum;
			logic        at_end;
			result_t     want;
			if (first)
				begin_table();
			if (idle)
				return;
			p = position;
			window = {window[55:0], b};
			if (p < 4) begin
				if (b != signature_reg[p * 8 +: 8])
					signature_ok = 1'b0;
			end else if (p < 8) begin
				length_field[(p - 4) * 8 +: 8] = b;
			end
			if (p == 7) begin
				count = (length_field < 8) ? length_field : 32'd8;
				sum = 8'h00;
				for (int i = 0; i < count; i++)
					sum += earlier(7 - i);
				checksum = sum;
			end else if (p > 7) begin
				checksum += b;
			end
			advance_phase(b);
			at_end = (p == 7 && length_field <= 8) ||
				(p > 7 && {1'b0, p} + 33'd1 == {1'b0, length_field});
			position = p + 1;
			if (!(at_end || last))
				return;
			idle = 1'b1;
			if (!signature_ok)
				want.status = ST_BAD_SIG;
			else if (!at_end)
				want.status = ST_TRUNCATED;
			else if (checksum != 8'h00)
				want.status = ST_BAD_SUM;
			else if (phase == PH_SEARCH)
				want.status = ST_NO_NAME;
			else if (phase == PH_CAPTURED)
				want.status = ST_OK;
			else
				want.status = ST_MALFORMED;
			want.sleep_type_a = (want.status == ST_OK) ? type_a : 8'h00;
			want.sleep_type_b = (want.status == ST_OK) ? type_b : 8'h00;
			want.table_length = length_field;
			expected_results.push_back(want);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d length %0h",
					$time, got.status, got.table_length);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("sleep_type_a", 32'(want.sleep_type_a), 32'(got.sleep_type_a));
			compare_field("sleep_type_b", 32'(want.sleep_type_b), 32'(got.sleep_type_b));
			compare_field("table_length", want.table_length, got.table_length);
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

// ----- tb/sv/testbench.sv -----
// Top-level testbench for acpi_dsdt_s5_sleep_type_parser: streams directed and random
// table images under varying idle patterns and register settings, checking every result.
// Depends on acpi_s5_pkg, the channel interfaces and acpi_s5_tb_pkg.
`timescale 1ns / 1ps

module testbench;
	import acpi_s5_pkg::*;
	import acpi_s5_tb_pkg::*;

	logic clk;
	logic arst_n;

	acpi_s5_byte_if   byte_ch();
	acpi_s5_result_if result_ch();
	acpi_s5_cfg_if    reg_ch();

	acpi_dsdt_s5_sleep_type_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tbl    (byte_ch),
		.res    (result_ch),
		.cfg    (reg_ch)
	);

	sleep_type_scoreboard sb = new();

	int unsigned tx_idle_pct = 33;
	int unsigned rx_idle_pct = 59;
	int unsigned bytes_sent = 0;
	logic [31:0] cur_sig = SIG_RESET;
	logic [31:0] cur_name = NAME_RESET;
	logic [7:0]  image[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("acpi_dsdt_s5_sleep_type_parser verification failed");
		$finish;
	end

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(negedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result('{result_ch.status, result_ch.sleep_type_a,
				result_ch.sleep_type_b, result_ch.table_length});
	end

	function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			q.push_back(w[k * 8 +: 8]);
	endfunction

	function automatic logic [7:0] sleep_value();
		return ($urandom_range(4) == 0) ? BYTE_PREFIX : 8'($urandom_range(255));
	endfunction

	function automatic void build_table(bit with_name);
		logic [7:0]  hdr[$];
		logic [7:0]  body[$];
		logic [7:0]  sum;
		int unsigned layout;
		int unsigned roll;
		int unsigned extra;
		int unsigned keep;
		layout = with_name ? (($urandom_range(99) < 15) ? $urandom_range(1, 2) : 0)
			: $urandom_range(3);
		if (!(with_name && layout != 0))
			repeat ($urandom_range(with_name ? 6 : 20)) body.push_back(8'($urandom_range(255)));
		if (with_name) begin
			if (layout == 0) begin
				roll = $urandom_range(19);
				body.push_back(roll == 0 ? 8'h09 : NAME_OP);
				if (roll[0])
					body.push_back(ROOT_CHAR);
			end
			push_word(body, cur_name);
			body.push_back($urandom_range(19) == 0 ? 8'h13 : PACKAGE_OP);
			extra = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
			body.push_back({extra[1:0], 6'($urandom_range(63))});
			repeat (extra) body.push_back(8'($urandom_range(255)));
			body.push_back(8'($urandom_range(255)));
			if ($urandom_range(1))
				body.push_back(BYTE_PREFIX);
			body.push_back(sleep_value());
			if ($urandom_range(1))
				body.push_back(BYTE_PREFIX);
			body.push_back(sleep_value());
			repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
			if ($urandom_range(99) < 8) begin
				keep = $urandom_range(body.size());
				while (body.size() > keep)
					void'(body.pop_back());
			end
		end else if (layout == 2) begin
			body.push_back(NAME_OP);
			for (int k = 0; k < $urandom_range(1, 3); k++)
				body.push_back(cur_name[k * 8 +: 8]);
		end else if (layout == 3) begin
			body.push_front(cur_name[31:24]);
			body.push_front(cur_name[23:16]);
		end
		push_word(hdr, cur_sig);
		push_word(hdr, 32'(36 + body.size()));
		repeat (28) hdr.push_back(8'($urandom_range(255)));
		if (with_name && layout == 1) begin
			hdr[35] = NAME_OP;
		end else if (with_name && layout == 2) begin
			hdr[34] = NAME_OP;
			hdr[35] = ROOT_CHAR;
		end else if (!with_name && layout == 1) begin
			hdr[31] = NAME_OP;
			for (int k = 0; k < 4; k++)
				hdr[32 + k] = cur_name[k * 8 +: 8];
		end else if (!with_name && layout == 3) begin
			hdr[33] = NAME_OP;
			hdr[34] = cur_name[7:0];
			hdr[35] = cur_name[15:8];
		end
		if ($urandom_range(99) < 8) begin
			roll = $urandom_range(3);
			hdr[roll] ^= 8'($urandom_range(1, 255));
		end
		hdr[9] = 8'h00;
		sum = 8'h00;
		foreach (hdr[k])
			sum += hdr[k];
		foreach (body[k])
			sum += body[k];
		hdr[9] = 8'h00 - sum;
		if ($urandom_range(99) < 8)
			hdr[9] += 8'($urandom_range(1, 255));
		image = {hdr, body};
	endfunction

	function automatic void build_short_table();
		image = {};
		push_word(image, ($urandom_range(9) == 0) ? $urandom() : cur_sig);
		push_word(image, $urandom_range(8));
	endfunction

	task automatic send_byte(input logic [7:0] d, input logic first, input logic last,
			input bit counted);
		bit took;
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= d;
		byte_ch.first_byte <= first;
		byte_ch.last_byte <= last;
		do begin
			@(negedge clk);
			took = byte_ch.ready;
			if (took)
				sb.note_byte(d, first, last);
			@(posedge clk);
		end while (!took);
		if (counted)
			bytes_sent++;
	endtask

	task automatic send_table(input bit close);
		foreach (image[i])
			send_byte(image[i], i == 0, close && i == image.size() - 1, 1'b1);
	endtask

	task automatic put_register(input logic [0:0] index, input logic [31:0] value);
		bit took;
		reg_ch.valid <= 1'b1;
		reg_ch.index <= index;
		reg_ch.data <= value;
		do begin
			@(negedge clk);
			took = reg_ch.ready;
			if (took)
				sb.set_register(index, value);
			@(posedge clk);
		end while (!took);
	endtask

	task automatic write_registers(input logic [31:0] sig, input logic [31:0] name);
		put_register(REG_TABLE_SIGNATURE, sig);
		put_register(REG_OBJECT_NAME, name);
		reg_ch.valid <= 1'b0;
		cur_sig = sig;
		cur_name = name;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_segment(input int unsigned quota);
		int unsigned stop_at;
		int unsigned roll;
		int unsigned keep;
		stop_at = bytes_sent + quota;
		while (bytes_sent < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
			end else if (roll < 12) begin
				build_short_table();
				send_table($urandom_range(1));
			end else if (roll < 30) begin
				build_table(1'b1);
				if (roll < 16) begin
					for (int k = 4; k < 8; k++)
						image[k] = (roll < 14) ? 8'hFF : 8'($urandom_range(255));
				end
				keep = $urandom_range(1, image.size() - 1);
				while (image.size() > keep)
					void'(image.pop_back());
				send_table(roll < 22);
			end else if (roll < 40) begin
				build_table(1'b0);
				send_table($urandom_range(99) < 70);
			end else begin
				build_table(1'b1);
				send_table($urandom_range(99) < 70);
			end
		end
	endtask

	initial begin
		logic [31:0] sig;
		logic [31:0] name;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		byte_ch.first_byte <= 1'b0;
		byte_ch.last_byte <= 1'b0;
		reg_ch.valid <= 1'b0;
		reg_ch.index <= REG_TABLE_SIGNATURE;
		reg_ch.data <= 32'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'hA5, 1'b0, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1, 1'b0);
		send_byte(SIG_RESET[7:0], 1'b1, 1'b1, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
		image = {};
		push_word(image, SIG_RESET);
		void'(image.pop_back());
		send_table(1'b0);
		image = {};
		push_word(image, SIG_RESET);
		push_word(image, 32'd0);
		send_table(1'b1);
		image = {};
		push_word(image, SIG_RESET);
		push_word(image, 32'hFFFF_FFFF);
		image.push_back(8'h00);
		send_table(1'b1);

		for (int seg = 0; seg < 6; seg++) begin
			wait_drained();
			tx_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 59 : 0;
			rx_idle_pct = (seg < 2) ? 59 : (seg < 4) ? 33 : 0;
			case (seg)
				0: begin sig = SIG_RESET;    name = NAME_RESET;   end
				1: begin sig = 32'd0;        name = 32'd0;        end
				2: begin sig = 32'hFFFF_FFFF; name = 32'hFFFF_FFFF; end
				3: begin sig = $urandom();   name = $urandom();   end
				4: begin sig = SIG_RESET;    name = $urandom();   end
				default: begin sig = $urandom(); name = NAME_RESET; end
			endcase
			write_registers(sig, name);
			run_segment(320);
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("acpi_dsdt_s5_sleep_type_parser verification clean");
		else
			$display("acpi_dsdt_s5_sleep_type_parser verification failed");
		$finish;
	end

endmodule
